FILE: hdl/sau_pkg.sv
`timescale 1ns / 1ps
// Package for the scalar aggregate unit: value width, mode and state encodings,
// the sign-extension and sentinel helpers. No dependencies.
package sau_pkg;

    localparam int VALUE_WIDTH = 64;
    // Width actually used, kept within 32..64
    localparam int VW = (VALUE_WIDTH < 32) ? 32 : ((VALUE_WIDTH > 64) ? 64 : VALUE_WIDTH);
    localparam logic [63:0] VMASK = (VW >= 64) ? {64{1'b1}} : ((64'd1 << VW) - 64'd1);

    typedef enum logic [2:0] {
        MODE_COUNT = 3'd0,
        MODE_SUM   = 3'd1,
        MODE_MIN   = 3'd2,
        MODE_MAX   = 3'd3,
        MODE_AVG   = 3'd4
    } t_agg_mode;

    // Register byte addresses (bit 2 selects the register)
    localparam logic [2:0] ADDR_MODE   = 3'd0;
    localparam logic [2:0] ADDR_NARROW = 3'd4;

    typedef enum logic [1:0] {
        S_ACC = 2'd0,
        S_FIN = 2'd1,
        S_DIV = 2'd2
    } t_top_state;

    typedef enum logic [2:0] {
        DV_IDLE  = 3'd0,
        DV_RUN   = 3'd1,
        DV_SIGN  = 3'd2,
        DV_DIFF  = 3'd3,
        DV_ROUND = 3'd4
    } t_div_state;

    typedef struct packed {
        logic clear;   // return to reset value for the given mode
        logic row;     // absorb one real row
    } t_acc_ctl;

    function automatic t_agg_mode to_mode(input logic [2:0] bits);
        t_agg_mode m;
        case (bits)
            MODE_COUNT: m = MODE_COUNT;
            MODE_SUM:   m = MODE_SUM;
            MODE_MIN:   m = MODE_MIN;
            MODE_MAX:   m = MODE_MAX;
            MODE_AVG:   m = MODE_AVG;
            default:    m = MODE_COUNT;
        endcase
        return m;
    endfunction

    // Sign-extend from 32 bits in narrow mode, else from VW bits
    function automatic logic [63:0] sext_w(input logic [63:0] x, input logic narrow);
        logic [63:0] y;
        for (int i = 0; i < 64; i++) begin
            if (narrow) begin
                y[i] = (i < 32) ? x[i] : x[31];
            end else begin
                y[i] = (i < VW) ? x[i] : x[VW-1];
            end
        end
        return y;
    endfunction

    function automatic logic [63:0] sentinel(input t_agg_mode m, input logic narrow);
        logic [63:0] maxv;
        logic [63:0] v;
        maxv = (narrow ? 64'h0000_0000_FFFF_FFFF : VMASK) >> 1;
        case (m)
            MODE_MIN: v = maxv;
            MODE_MAX: v = ~maxv;
            default:  v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/sau_accum.sv
`timescale 1ns / 1ps
// Running value and row count: one add or signed compare per real row.
// Depends on sau_pkg.
module sau_accum
    import sau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_acc_ctl    i_ctl,
    input  t_agg_mode   i_mode,
    input  logic        i_narrow,
    input  logic [63:0] i_value,
    output logic [63:0] o_value,
    output logic [63:0] o_count
);

    logic [63:0] r_value, n_value;
    logic [63:0] r_count, n_count;
    logic [63:0] w_v;

    assign w_v = sext_w(i_value, i_narrow);

    always_comb begin
        n_value = r_value;
        n_count = r_count;
        if (i_ctl.clear) begin
            n_value = sentinel(i_mode, i_narrow);
            n_count = '0;
        end else if (i_ctl.row) begin
            n_count = r_count + 64'd1;
            case (i_mode)
                MODE_SUM, MODE_AVG: n_value = sext_w(r_value + w_v, i_narrow);
                MODE_MIN: if ($signed(w_v) < $signed(r_value)) n_value = w_v;
                MODE_MAX: if ($signed(r_value) < $signed(w_v)) n_value = w_v;
                default:  n_value = r_value;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_count <= '0;
        end else begin
            r_value <= n_value;
            r_count <= n_count;
        end
    end

    assign o_value = r_value;
    assign o_count = r_count;

endmodule

FILE: hdl/sau_divider.sv
`timescale 1ns / 1ps
// Signed rounding divider: restoring, one quotient bit per cycle through one
// trial subtractor, then sign fix and round-up step. Depends on sau_pkg.
module sau_divider
    import sau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_sum,
    input  logic [63:0] i_count,
    output logic        o_busy,
    output logic [63:0] o_quot
);

    t_div_state  r_state, n_state;
    logic [5:0]  r_step, n_step;
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_quo, n_quo;
    logic [63:0] r_div, n_div;
    logic [63:0] r_cnt, n_cnt;
    logic        r_sn, n_sn;
    logic        r_cn, n_cn;
    logic [63:0] w_op_a, w_op_b, w_sub;
    logic [65:0] w_trial;

    // trial subtract for the restoring step
    assign w_trial = {1'b0, r_rem, r_quo[63]} - {2'b00, r_div};

    // subtractor for the rounding difference
    assign w_sub = w_op_a - w_op_b;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_div   = r_div;
        n_cnt   = r_cnt;
        n_sn    = r_sn;
        n_cn    = r_cn;
        w_op_a  = '0;
        w_op_b  = '0;
        case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    n_sn    = i_sum[63];
                    n_cn    = i_count[63];
                    n_quo   = i_sum[63] ? (64'd0 - i_sum) : i_sum;
                    n_div   = i_count[63] ? (64'd0 - i_count) : i_count;
                    n_cnt   = i_count;
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = DV_RUN;
                end
            end
            DV_RUN: begin
                if (!w_trial[65]) begin
                    n_rem = w_trial[63:0];
                    n_quo = {r_quo[62:0], 1'b1};
                end else begin
                    n_rem = {r_rem[62:0], r_quo[63]};
                    n_quo = {r_quo[62:0], 1'b0};
                end
                n_step = r_step + 6'd1;
                if (r_step == 6'd63) n_state = DV_SIGN;
            end
            DV_SIGN: begin
                if (r_sn ^ r_cn) n_quo = 64'd0 - r_quo;
                if (r_sn) n_rem = 64'd0 - r_rem;
                n_state = DV_DIFF;
            end
            DV_DIFF: begin
                // r_div takes count minus remainder for the rounding compare
                w_op_a  = r_cnt;
                w_op_b  = r_rem;
                n_div   = w_sub;
                n_state = DV_ROUND;
            end
            DV_ROUND: begin
                if (!($signed(r_rem) < $signed(r_div))) n_quo = r_quo + 64'd1;
                n_state = DV_IDLE;
            end
            default: n_state = DV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
        r_cnt <= n_cnt;
        r_sn  <= n_sn;
        r_cn  <= n_cn;
    end

    assign o_busy = (r_state != DV_IDLE);
    assign o_quot = r_quo;

endmodule

FILE: hdl/scalar_aggregate_unit.sv
`timescale 1ns / 1ps
// Rows are taken one per cycle while accumulating; the last row of a run passes a finish state
// (held there while the previous result still waits), after which count, sum, min and max
// sit in the output register. A non-empty average runs the divider: a start step, the quotient
// bits, then sign fix and rounding steps. Input is held off meanwhile.
// Synchronous active-low reset: mode count, wide values, state cleared, no result.
// Depends on sau_pkg, sau_accum, sau_divider.
module scalar_aggregate_unit
    import sau_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // row stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [63:0] value
    input  logic        i_s_axis_tuser,   // [0] dummy
    input  logic        i_s_axis_tlast,   // last_row
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [63:0] aggregate
    output logic        o_m_axis_tuser,   // [0] empty_average
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_top_state  r_state, n_state;
    logic [2:0]  r_mode, n_mode;
    logic        r_narrow, n_narrow;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_out_data, n_out_data;
    logic        r_out_empty, n_out_empty;
    logic        w_cfg_wr;
    logic        w_in_acc;
    logic        w_out_free;
    logic        w_div_start;
    logic        w_div_busy;
    logic [63:0] w_quot;
    logic [63:0] w_acc_value;
    logic [63:0] w_acc_count;
    t_acc_ctl    w_acc_ctl;
    t_agg_mode   w_mode;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = paddr[2] ? {31'd0, r_narrow} : {29'd0, r_mode};

    always_comb begin
        n_mode   = r_mode;
        n_narrow = r_narrow;
        if (w_cfg_wr) begin
            if (paddr[2] == ADDR_NARROW[2]) n_narrow = pwdata[0];
            else                            n_mode   = pwdata[2:0];
        end
    end

    assign w_mode          = to_mode(r_mode);
    assign o_s_axis_tready = (r_state == S_ACC);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state         = r_state;
        w_acc_ctl.clear = w_cfg_wr;
        w_acc_ctl.row   = 1'b0;
        w_div_start     = 1'b0;
        n_out_valid     = r_out_valid && !i_m_axis_tready;
        n_out_data      = r_out_data;
        n_out_empty     = r_out_empty;
        case (r_state)
            S_ACC: begin
                if (w_in_acc) begin
                    w_acc_ctl.row = !i_s_axis_tuser;
                    if (i_s_axis_tlast) n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_mode == MODE_AVG && w_acc_count != 64'd0) begin
                    // divider captures sum and count at this edge
                    w_div_start     = 1'b1;
                    w_acc_ctl.clear = 1'b1;
                    n_state         = S_DIV;
                end else if (w_out_free) begin
                    n_out_valid     = 1'b1;
                    n_out_data      = (w_mode == MODE_COUNT) ? w_acc_count :
                                      (w_mode == MODE_AVG)   ? 64'd0 : w_acc_value;
                    n_out_empty     = (w_mode == MODE_AVG);
                    w_acc_ctl.clear = 1'b1;
                    n_state         = S_ACC;
                end
            end
            S_DIV: begin
                if (!w_div_busy && w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = sext_w(w_quot, r_narrow);
                    n_out_empty = 1'b0;
                    n_state     = S_ACC;
                end
            end
            default: n_state = S_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_mode      <= MODE_COUNT;
            r_narrow    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_narrow    <= n_narrow;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_out_empty <= n_out_empty;
    end

    sau_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_acc_ctl),
        .i_mode   (to_mode(n_mode)),
        .i_narrow (n_narrow),
        .i_value  (i_s_axis_tdata),
        .o_value  (w_acc_value),
        .o_count  (w_acc_count)
    );

    sau_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (w_acc_value),
        .i_count (w_acc_count),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_empty;

endmodule
